// ===== design/csa_pkg.sv =====
package csa_pkg;

   // Pool size and the widths that follow from it.
   localparam int SLOTS  = 32;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int FREE_W = $clog2(SLOTS + 1);
   localparam int CALL_W = 31;
   localparam int OP_W   = 2;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC_ANY   = 2'd0,
      OP_ALLOC_NAMED = 2'd1,
      OP_RELEASE     = 2'd2,
      OP_LOOKUP      = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SEARCH = 4'b0010,
      ST_UPDATE = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   // One write into the slot table per cycle.
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      logic              busy;
      logic [SLOT_W-1:0] rank;
      logic              call_en;
      logic [CALL_W-1:0] call;
      logic              free_dec;
      logic              free_inc;
   } tbl_write_type;

   // Finished operation handed to the response register.
   typedef struct packed {
      logic              done;
      logic              ok;
      logic [SLOT_W-1:0] slot;
   } result_type;

endpackage

// ===== design/channel_slot_allocator_unit.sv =====
// Channel slot allocator: a pool of 32 slots kept in an ordered free list.
// The request channel (req_valid, req_stall, req_operation, req_call_id,
// req_slot_index) takes one word at a time: allocate any free slot, allocate
// a named slot, release a slot, or look up the oldest slot bound to a call id.
// Every request produces exactly one response word on the rsp_ channel with a
// success flag, the slot number (zero on failure) and the free count after
// the operation.
// All work is done by one sequencer that walks the slot table one entry per
// cycle through a single read port and a single write port. A lookup searches
// every entry; an allocate-any searches until it finds the head of the free
// list and then walks every entry to update the ranks; a named allocate or
// release checks its slot once, then walks every entry to update, and skips
// the update when it fails. req_stall stays high from the accept until the
// result is handed over.
// Reset empties the pool: every slot is free, ranked in slot order, and the
// free count is 32. If the receiver stalls, the response word holds in the
// output register; the next request may be accepted and processed meanwhile,
// and its result waits in the sequencer until the register frees up.
module channel_slot_allocator_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [csa_pkg::OP_W-1:0]      req_operation,
   input  logic [csa_pkg::CALL_W-1:0]    req_call_id,
   input  logic [csa_pkg::SLOT_W-1:0]    req_slot_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_ok,
   output logic [csa_pkg::SLOT_W-1:0]    rsp_slot_found,
   output logic [csa_pkg::FREE_W-1:0]    rsp_free_slots
);

   logic [csa_pkg::SLOT_W-1:0] rd_addr;
   logic                       rd_busy;
   logic [csa_pkg::SLOT_W-1:0] rd_rank;
   logic [csa_pkg::CALL_W-1:0] rd_call;
   logic [csa_pkg::FREE_W-1:0] free_total;
   csa_pkg::tbl_write_type     wr;
   csa_pkg::result_type        result;
   logic                       out_ready;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_ok_ff;
   logic [csa_pkg::SLOT_W-1:0] rsp_slot_ff;
   logic [csa_pkg::FREE_W-1:0] rsp_free_ff;

   csa_slot_table u_table (
      .clock      (clock),
      .reset      (reset),
      .rd_addr    (rd_addr),
      .rd_busy    (rd_busy),
      .rd_rank    (rd_rank),
      .rd_call    (rd_call),
      .wr         (wr),
      .free_total (free_total)
   );

   csa_sequencer u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_call_id    (req_call_id),
      .req_slot_index (req_slot_index),
      .rd_addr        (rd_addr),
      .rd_busy        (rd_busy),
      .rd_rank        (rd_rank),
      .rd_call        (rd_call),
      .free_total     (free_total),
      .wr             (wr),
      .out_ready      (out_ready),
      .result         (result)
   );

   // The output register can take a new word when empty or being drained.
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result.done && out_ready) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The free count is sampled after the table update has settled.
   always_ff @(posedge clock) begin
      if (result.done && out_ready) begin
         rsp_ok_ff   <= result.ok;
         rsp_slot_ff <= result.ok ? result.slot : '0;
         rsp_free_ff <= free_total;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_slot_found = rsp_slot_ff;
   assign rsp_free_slots = rsp_free_ff;

   // A failed operation never reports a slot number.
   a_fail_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_slot_found == '0))
      else $error("failed response carries a nonzero slot");

   // The free count never exceeds the pool size.
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_free_slots} <= (csa_pkg::FREE_W + 1)'(csa_pkg::SLOTS)))
      else $error("free count exceeds pool size");

   // Once a word is accepted the sequencer is busy on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request channel open right after an accept");

   // A completed result is loaded into the output register and shown the next cycle.
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (result.done && out_ready) |=> rsp_valid)
      else $error("completed result was not presented");

endmodule

// ===== design/csa_slot_table.sv =====
module csa_slot_table (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [csa_pkg::SLOT_W-1:0]         rd_addr,
   output logic                               rd_busy,
   output logic [csa_pkg::SLOT_W-1:0]         rd_rank,
   output logic [csa_pkg::CALL_W-1:0]         rd_call,
   input  csa_pkg::tbl_write_type             wr,
   output logic [csa_pkg::FREE_W-1:0]         free_total
);

   logic                       busy_ff [csa_pkg::SLOTS];
   logic [csa_pkg::SLOT_W-1:0] rank_ff [csa_pkg::SLOTS];
   logic [csa_pkg::CALL_W-1:0] call_ff [csa_pkg::SLOTS];
   logic [csa_pkg::FREE_W-1:0] free_total_ff;
   logic [csa_pkg::FREE_W-1:0] free_total_in;

   // Every field is read at the single address the sequencer drives.
   assign rd_busy    = busy_ff[rd_addr];
   assign rd_rank    = rank_ff[rd_addr];
   assign rd_call    = call_ff[rd_addr];
   assign free_total = free_total_ff;

   always_comb begin
      free_total_in = free_total_ff;
      if (wr.en && wr.free_dec) begin
         free_total_in = free_total_ff - 1'b1;
      end else if (wr.en && wr.free_inc) begin
         free_total_in = free_total_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < csa_pkg::SLOTS; i++) begin
            busy_ff[i] <= 1'b0;
            rank_ff[i] <= csa_pkg::SLOT_W'(i);
         end
         free_total_ff <= csa_pkg::FREE_W'(csa_pkg::SLOTS);
      end else begin
         if (wr.en) begin
            busy_ff[wr.addr] <= wr.busy;
            rank_ff[wr.addr] <= wr.rank;
         end
         free_total_ff <= free_total_in;
      end
   end

   // Call ids carry no reset; they are only read for slots in use.
   always_ff @(posedge clock) begin
      if (wr.en && wr.call_en) begin
         call_ff[wr.addr] <= wr.call;
      end
   end

endmodule

// ===== design/csa_sequencer.sv =====
module csa_sequencer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [csa_pkg::OP_W-1:0]           req_operation,
   input  logic [csa_pkg::CALL_W-1:0]         req_call_id,
   input  logic [csa_pkg::SLOT_W-1:0]         req_slot_index,
   output logic [csa_pkg::SLOT_W-1:0]         rd_addr,
   input  logic                               rd_busy,
   input  logic [csa_pkg::SLOT_W-1:0]         rd_rank,
   input  logic [csa_pkg::CALL_W-1:0]         rd_call,
   input  logic [csa_pkg::FREE_W-1:0]         free_total,
   output csa_pkg::tbl_write_type             wr,
   input  logic                               out_ready,
   output csa_pkg::result_type                result
);

   localparam logic [csa_pkg::SLOT_W-1:0] LAST = csa_pkg::SLOT_W'(csa_pkg::SLOTS - 1);

   csa_pkg::state_type         state_ff, state_in;
   csa_pkg::op_type            op_ff, op_in;
   logic [csa_pkg::CALL_W-1:0] cid_ff, cid_in;
   logic [csa_pkg::SLOT_W-1:0] idx_ff, idx_in;
   logic [csa_pkg::SLOT_W-1:0] cnt_ff, cnt_in;
   logic                       found_ff, found_in;
   logic [csa_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic [csa_pkg::SLOT_W-1:0] rank_ff, rank_in;
   logic                       cnt_last;
   logic                       idx_ok;
   logic                       taking;
   logic                       direct;
   logic [csa_pkg::FREE_W-1:0] busy_total;

   assign req_stall  = (state_ff != csa_pkg::ST_IDLE);
   assign cnt_last   = (cnt_ff == LAST);
   assign idx_ok     = ({1'b0, idx_ff} < csa_pkg::FREE_W'(csa_pkg::SLOTS));
   assign taking     = (op_ff != csa_pkg::OP_RELEASE);
   assign direct     = (op_ff == csa_pkg::OP_ALLOC_NAMED) || (op_ff == csa_pkg::OP_RELEASE);
   assign busy_total = csa_pkg::FREE_W'(csa_pkg::SLOTS) - free_total;

   // Named allocate and release read their slot directly in the search; all else walks the counter.
   assign rd_addr = (state_ff == csa_pkg::ST_SEARCH && direct) ? idx_ff : cnt_ff;

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      cid_in      = cid_ff;
      idx_in      = idx_ff;
      cnt_in      = cnt_ff;
      found_in    = found_ff;
      slot_in     = slot_ff;
      rank_in     = rank_ff;
      wr          = '0;
      result      = '0;
      result.ok   = found_ff;
      result.slot = slot_ff;
      case (state_ff)
         csa_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in    = csa_pkg::op_type'(req_operation);
               cid_in   = req_call_id;
               idx_in   = req_slot_index;
               cnt_in   = '0;
               found_in = 1'b0;
               slot_in  = '0;
               rank_in  = '0;
               state_in = csa_pkg::ST_SEARCH;
            end
         end
         csa_pkg::ST_SEARCH: begin
            case (op_ff)
               csa_pkg::OP_ALLOC_ANY: begin
                  if (!rd_busy && rd_rank == '0) begin
                     found_in = 1'b1;
                     slot_in  = cnt_ff;
                     rank_in  = '0;
                     cnt_in   = '0;
                     state_in = csa_pkg::ST_UPDATE;
                  end else if (cnt_last) begin
                     state_in = csa_pkg::ST_FINISH;
                  end else begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
               csa_pkg::OP_ALLOC_NAMED, csa_pkg::OP_RELEASE: begin
                  if (idx_ok && (rd_busy == !taking)) begin
                     found_in = 1'b1;
                     slot_in  = idx_ff;
                     rank_in  = rd_rank;
                     cnt_in   = '0;
                     state_in = csa_pkg::ST_UPDATE;
                  end else begin
                     state_in = csa_pkg::ST_FINISH;
                  end
               end
               csa_pkg::OP_LOOKUP: begin
                  // Keep the matching slot with the smallest allocation rank.
                  if (rd_busy && rd_call == cid_ff && (!found_ff || rd_rank < rank_ff)) begin
                     found_in = 1'b1;
                     slot_in  = cnt_ff;
                     rank_in  = rd_rank;
                  end
                  if (cnt_last) begin
                     state_in = csa_pkg::ST_FINISH;
                  end else begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
               default: begin
                  state_in = csa_pkg::ST_FINISH;
               end
            endcase
         end
         csa_pkg::ST_UPDATE: begin
            wr.addr = cnt_ff;
            wr.call = cid_ff;
            if (cnt_ff == slot_ff) begin
               // The moved slot joins the tail of the list it enters.
               wr.en       = 1'b1;
               wr.busy     = taking;
               wr.rank     = taking ? busy_total[csa_pkg::SLOT_W-1:0]
                                    : free_total[csa_pkg::SLOT_W-1:0];
               wr.call_en  = taking;
               wr.free_dec = taking;
               wr.free_inc = !taking;
            end else if ((rd_busy == !taking) && rd_rank > rank_ff) begin
               // Close the gap left in the list the slot leaves.
               wr.en   = 1'b1;
               wr.busy = rd_busy;
               wr.rank = rd_rank - 1'b1;
            end
            if (cnt_last) begin
               state_in = csa_pkg::ST_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         csa_pkg::ST_FINISH: begin
            result.done = 1'b1;
            if (out_ready) begin
               state_in = csa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = csa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csa_pkg::ST_IDLE;
         cnt_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      cid_ff  <= cid_in;
      idx_ff  <= idx_in;
      slot_ff <= slot_in;
      rank_ff <= rank_in;
   end

endmodule
